// ----- rtl/core/gcmbx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcmbx_pkg
// Shared types, constants and helpers for the generation checked mailbox.
// ----------------------------------------------------------------------------
package gcmbx_pkg;

	localparam int ENDPOINTS     = 8;
	localparam int QUEUE_DEPTH   = 8;
	localparam int MESSAGE_BYTES = 64;

	localparam int SLOT_W = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int BIDX_W = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
	localparam int LEN_W  = 7;
	localparam int META_AW = SLOT_W + QPTR_W;
	localparam int MSG_AW  = SLOT_W + QPTR_W + BIDX_W;

	localparam logic [15:0] HANDLE_TAG = 16'h4950;
	localparam logic [31:0] GEN_SEED   = 32'h49500001;
	localparam logic [31:0] GEN_MULT   = 32'h9E3779B9;

	localparam logic [2:0] KIND_CREATE  = 3'd0;
	localparam logic [2:0] KIND_DESTROY = 3'd1;
	localparam logic [2:0] KIND_SEND    = 3'd2;
	localparam logic [2:0] KIND_RECV    = 3'd3;
	localparam logic [2:0] KIND_PENDING = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] handle;
		logic [63:0] pid;
		logic [7:0]  data_byte;
		logic        last;
		logic [6:0]  capacity;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] value;
		logic [7:0]  data_byte_res;
		logic [6:0]  msg_length;
		logic [63:0] sender;
		logic        end_of_run;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_META,
		ST_RREAD,
		ST_REMIT,
		ST_CRD,
		ST_CWR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic meta_chk;
		logic rd_issue;
		logic emit_byte;
		logic copy_rd;
		logic copy_wr;
		logic emit_resp;
	} cmd_t;

	typedef struct packed {
		logic recv_go;
		logic copy_go;
		logic len_ok;
		logic last_byte;
		logic copy_done;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] gen_reset(input int slot);
		logic [31:0] s1;
		s1 = 32'(slot + 1);
		return GEN_SEED ^ (s1 * GEN_MULT);
	endfunction

	function automatic logic [63:0] handle_of(input logic [31:0] gen,
		input logic [SLOT_W-1:0] slot);
		logic [7:0] enc;
		enc = 8'(slot) + 8'd1;
		return {HANDLE_TAG, 8'h00, gen, enc};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/gcmbx_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcmbx_ctrl
// Sequencer: steps one item through evaluate, copy or receive and response.
// ----------------------------------------------------------------------------
module gcmbx_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire gcmbx_pkg::sts_t  sts,
	output gcmbx_pkg::cmd_t       cmd
);

	gcmbx_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcmbx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gcmbx_pkg::ST_IDLE: begin
				if (req_valid) state_d = gcmbx_pkg::ST_EVAL;
			end
			gcmbx_pkg::ST_EVAL: begin
				if (sts.recv_go) state_d = gcmbx_pkg::ST_META;
				else if (sts.copy_go) state_d = gcmbx_pkg::ST_CRD;
				else state_d = gcmbx_pkg::ST_RESP;
			end
			gcmbx_pkg::ST_META: begin
				state_d = sts.len_ok ? gcmbx_pkg::ST_RREAD : gcmbx_pkg::ST_RESP;
			end
			gcmbx_pkg::ST_RREAD: state_d = gcmbx_pkg::ST_REMIT;
			gcmbx_pkg::ST_REMIT: begin
				if (sts.out_free) begin
					state_d = sts.last_byte ? gcmbx_pkg::ST_IDLE : gcmbx_pkg::ST_RREAD;
				end
			end
			gcmbx_pkg::ST_CRD: state_d = gcmbx_pkg::ST_CWR;
			gcmbx_pkg::ST_CWR: begin
				state_d = sts.copy_done ? gcmbx_pkg::ST_RESP : gcmbx_pkg::ST_CRD;
			end
			gcmbx_pkg::ST_RESP: begin
				if (sts.out_free) state_d = gcmbx_pkg::ST_IDLE;
			end
			default: state_d = gcmbx_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			gcmbx_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.capture = req_valid;
			end
			gcmbx_pkg::ST_EVAL:  cmd.eval = 1'b1;
			gcmbx_pkg::ST_META:  cmd.meta_chk = 1'b1;
			gcmbx_pkg::ST_RREAD: cmd.rd_issue = 1'b1;
			gcmbx_pkg::ST_REMIT: cmd.emit_byte = sts.out_free;
			gcmbx_pkg::ST_CRD:   cmd.copy_rd = 1'b1;
			gcmbx_pkg::ST_CWR:   cmd.copy_wr = 1'b1;
			gcmbx_pkg::ST_RESP:  cmd.emit_resp = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/gcmbx_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcmbx_dp
// Endpoint tables, staging buffer, message and meta memories, result register.
// ----------------------------------------------------------------------------
module gcmbx_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire gcmbx_pkg::req_t  req,
	input  wire gcmbx_pkg::cmd_t  cmd,
	output gcmbx_pkg::sts_t       sts,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output gcmbx_pkg::rsp_t       rsp
);

	localparam int SW = gcmbx_pkg::SLOT_W;
	localparam int QW = gcmbx_pkg::QPTR_W;
	localparam int CW = gcmbx_pkg::QCNT_W;
	localparam int BW = gcmbx_pkg::BIDX_W;
	localparam int LW = gcmbx_pkg::LEN_W;

	logic           used_q  [gcmbx_pkg::ENDPOINTS];
	logic [31:0]    gen_q   [gcmbx_pkg::ENDPOINTS];
	logic [63:0]    rcv_q   [gcmbx_pkg::ENDPOINTS];
	logic [QW-1:0]  head_q  [gcmbx_pkg::ENDPOINTS];
	logic [QW-1:0]  tail_q  [gcmbx_pkg::ENDPOINTS];
	logic [CW-1:0]  count_q [gcmbx_pkg::ENDPOINTS];
	logic [LW-1:0]  stg_cnt_q;
	logic           stg_ovf_q;

	logic [7:0]     stg_mem [gcmbx_pkg::MESSAGE_BYTES];
	logic [7:0]     msg_mem [1 << gcmbx_pkg::MSG_AW];
	logic [63+LW:0] meta_mem [1 << gcmbx_pkg::META_AW];

	gcmbx_pkg::req_t item_q;
	logic [SW-1:0]  slot_q;
	logic [QW-1:0]  hd_q, tl_q;
	logic [BW-1:0]  idx_q;
	logic [LW-1:0]  len_q;
	logic [63:0]    sender_q, value_q;
	logic           ok_q;
	logic [63+LW:0] meta_rd_q;
	logic [7:0]     msg_rd_q, stg_rd_q;
	logic           out_valid_q;
	gcmbx_pkg::rsp_t out_q;

	logic [7:0]     enc;
	logic [SW-1:0]  rslot, fslot;
	logic           hit, found, stg_full, ovf_new, rcv_ok, copy_go, recv_go;
	logic [LW-1:0]  new_len, mlen;
	logic [31:0]    gnew, gnext;
	logic           ok_d;
	logic [63:0]    value_d;

	function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
		return (p == QW'(gcmbx_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		enc   = item_q.handle[7:0];
		rslot = SW'(enc - 8'd1);
		hit = (item_q.handle[63:48] == gcmbx_pkg::HANDLE_TAG) && (enc != 8'd0)
			&& (enc <= 8'(gcmbx_pkg::ENDPOINTS)) && used_q[rslot]
			&& (item_q.handle == gcmbx_pkg::handle_of(gen_q[rslot], rslot));
		found = 1'b0;
		fslot = '0;
		for (int i = gcmbx_pkg::ENDPOINTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				found = 1'b1;
				fslot = SW'(i);
			end
		end
		gnew  = (gen_q[fslot] == 32'd0) ? 32'd1 : gen_q[fslot];
		gnext = (gen_q[rslot] + 32'd1 == 32'd0) ? 32'd1 : gen_q[rslot] + 32'd1;
		stg_full = (stg_cnt_q >= LW'(gcmbx_pkg::MESSAGE_BYTES));
		ovf_new  = stg_ovf_q || stg_full;
		new_len  = stg_full ? stg_cnt_q : stg_cnt_q + 1'b1;
		rcv_ok   = hit && (rcv_q[rslot] == item_q.pid);
		copy_go  = (item_q.kind == gcmbx_pkg::KIND_SEND) && item_q.last && hit
			&& (item_q.pid != 64'd0) && !ovf_new
			&& (count_q[rslot] < CW'(gcmbx_pkg::QUEUE_DEPTH));
		recv_go  = (item_q.kind == gcmbx_pkg::KIND_RECV) && rcv_ok
			&& (count_q[rslot] != '0);
		mlen = meta_rd_q[LW-1:0];
		ok_d = 1'b0;
		value_d = 64'd0;
		case (item_q.kind)
			gcmbx_pkg::KIND_CREATE: begin
				if (item_q.pid != 64'd0 && found) begin
					ok_d = 1'b1;
					value_d = gcmbx_pkg::handle_of(gnew, fslot);
				end
			end
			gcmbx_pkg::KIND_DESTROY: ok_d = hit;
			gcmbx_pkg::KIND_SEND: ok_d = item_q.last ? copy_go : !stg_full;
			gcmbx_pkg::KIND_PENDING: begin
				ok_d = rcv_ok;
				value_d = rcv_ok ? 64'(count_q[rslot]) : 64'd0;
			end
			default: ok_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gcmbx_pkg::ENDPOINTS; i++) begin
				used_q[i]  <= 1'b0;
				gen_q[i]   <= gcmbx_pkg::gen_reset(i);
				rcv_q[i]   <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
			stg_cnt_q   <= '0;
			stg_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				case (item_q.kind)
					gcmbx_pkg::KIND_CREATE: begin
						if (item_q.pid != 64'd0 && found) begin
							used_q[fslot]  <= 1'b1;
							gen_q[fslot]   <= gnew;
							rcv_q[fslot]   <= item_q.pid;
							head_q[fslot]  <= '0;
							tail_q[fslot]  <= '0;
							count_q[fslot] <= '0;
						end
					end
					gcmbx_pkg::KIND_DESTROY: begin
						if (hit) begin
							used_q[rslot]  <= 1'b0;
							gen_q[rslot]   <= gnext;
							rcv_q[rslot]   <= '0;
							head_q[rslot]  <= '0;
							tail_q[rslot]  <= '0;
							count_q[rslot] <= '0;
						end
					end
					gcmbx_pkg::KIND_SEND: begin
						if (item_q.last) begin
							stg_cnt_q <= '0;
							stg_ovf_q <= 1'b0;
						end else begin
							stg_cnt_q <= new_len;
							stg_ovf_q <= ovf_new;
						end
						if (copy_go) begin
							head_q[rslot]  <= ptr_inc(head_q[rslot]);
							count_q[rslot] <= count_q[rslot] + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.meta_chk && sts.len_ok) begin
				tail_q[slot_q]  <= ptr_inc(tl_q);
				count_q[slot_q] <= count_q[slot_q] - 1'b1;
			end
			if (cmd.emit_byte || cmd.emit_resp) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= req;
		if (cmd.eval) begin
			slot_q  <= rslot;
			hd_q    <= head_q[rslot];
			tl_q    <= tail_q[rslot];
			idx_q   <= '0;
			ok_q    <= ok_d;
			value_q <= value_d;
			len_q   <= new_len;
			meta_rd_q <= meta_mem[{rslot, tail_q[rslot]}];
			if (item_q.kind == gcmbx_pkg::KIND_SEND && !stg_full) begin
				stg_mem[stg_cnt_q[BW-1:0]] <= item_q.data_byte;
			end
			if (copy_go) meta_mem[{rslot, head_q[rslot]}] <= {item_q.pid, new_len};
		end
		if (cmd.meta_chk) begin
			len_q    <= mlen;
			sender_q <= meta_rd_q[63+LW:LW];
		end
		if (cmd.rd_issue) msg_rd_q <= msg_mem[{slot_q, tl_q, idx_q}];
		if (cmd.copy_rd) stg_rd_q <= stg_mem[idx_q];
		if (cmd.copy_wr) begin
			msg_mem[{slot_q, hd_q, idx_q}] <= stg_rd_q;
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.emit_byte) begin
			out_q <= '{ok: 1'b1, value: 64'd0, data_byte_res: msg_rd_q,
				msg_length: len_q, sender: sender_q, end_of_run: sts.last_byte};
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.emit_resp) begin
			out_q <= '{ok: ok_q, value: value_q, data_byte_res: 8'd0,
				msg_length: 7'd0, sender: 64'd0, end_of_run: 1'b1};
		end
	end

	always_comb begin
		sts.recv_go   = recv_go;
		sts.copy_go   = copy_go;
		sts.len_ok    = (mlen != '0) && (mlen <= LW'(gcmbx_pkg::MESSAGE_BYTES))
			&& (item_q.capacity >= mlen);
		sts.last_byte = (LW'(idx_q) + 1'b1 == len_q);
		sts.copy_done = (LW'(idx_q) + 1'b1 == len_q);
		sts.out_free  = !out_valid_q || rsp_ready;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/generation_checked_mailbox.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// generation_checked_mailbox
// Mailbox endpoint table with generation checked handles.
// ----------------------------------------------------------------------------
// Most items give a single result, after the evaluate and response states.
// Send with last, when accepted, first copies the staged bytes into the queue (read, then write).
// Receive: after the meta check each byte is read, then emitted, waiting while the result stalls.
// Throughput: one item at a time; the next item is taken once this one ends.
// Reset: arst_n clears all endpoints and staging and seeds the generations.
// ----------------------------------------------------------------------------
module generation_checked_mailbox (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire gcmbx_pkg::req_t  req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output gcmbx_pkg::rsp_t       rsp
);

	gcmbx_pkg::cmd_t cmd;
	gcmbx_pkg::sts_t sts;

	gcmbx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gcmbx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ----- rtl/core/gcmbx_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcmbx_checker
// Port-level checks on the mailbox result stream.
// ----------------------------------------------------------------------------
module gcmbx_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire gcmbx_pkg::rsp_t  rsp
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_run_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.end_of_run |-> rsp.ok && rsp.msg_length != 7'd0)
		else $error("partial run item without success");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.value == 64'd0 && rsp.sender == 64'd0
			&& rsp.msg_length == 7'd0 && rsp.end_of_run)
		else $error("rejected item carries data");

	a_byte_novalue: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.msg_length != 7'd0 |-> rsp.value == 64'd0)
		else $error("received byte carries a value");

endmodule

bind generation_checked_mailbox gcmbx_checker u_gcmbx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire
